FILE: rtl/mlfqs_pkg.sv
// mlfqs_pkg: shared types, constants and helpers of the feedback-queue scheduler
// used by mlfqs_cell, mlfqs_ctrl and mlfq_process_scheduler_top
// no dependencies
`default_nettype none

package mlfqs_pkg;

    localparam int SLOT_W     = 6;
    localparam int LEVELS     = 4;
    localparam int LVL_W      = 2;
    localparam int TICK_W     = 8;
    localparam int CNT_W      = 7;
    localparam int TIMER_W    = 16;
    localparam int MASK_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX  = 7'd64;
    localparam logic [TICK_W-1:0] TICK_MAX = 8'hff;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hffff;
    localparam logic [LVL_W-1:0]  LVL_LAST = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_TICK   = 3'd2,
        OP_YIELD  = 3'd3,
        OP_PICK   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef logic [LEVELS-1:0][CNT_W-1:0]  counts_t;
    typedef logic [LEVELS-1:0][TICK_W-1:0] slices_t;

    // command broadcast to every cell
    typedef struct packed {
        logic              exec;
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic              running;
        logic              boost;
        slices_t           slices;
    } cmd_t;

    // answer of the addressed cell, zero from all others
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             demote;
    } resp_t;

    // token that walks the row of cells one hop per cycle
    typedef struct packed {
        logic                          active;
        logic                          boost;
        logic                          pick;
        logic [LEVELS-1:0]             hit;
        logic [LEVELS-1:0][SLOT_W-1:0] idx;
        counts_t                       counts;
    } carry_t;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_MAX) ? CNT_W'(c + 7'd1) : c;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
        return (c != '0) ? CNT_W'(c - 7'd1) : c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mlfqs_cell.sv
// mlfqs_cell: one process slot (level, slice ticks, yield flag) plus one hop of the scan row
// depends on mlfqs_pkg
`default_nettype none

module mlfqs_cell #(
    parameter int IDX = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mlfqs_pkg::cmd_t     cmd,
    input  wire                 live_bit,
    input  wire                 run_bit,
    input  mlfqs_pkg::carry_t   carry_in,
    output mlfqs_pkg::carry_t   carry_out,
    output mlfqs_pkg::resp_t    resp
);
    import mlfqs_pkg::*;

    logic [LVL_W-1:0]  level_reg, level_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              yield_reg, yield_next;
    carry_t            carry_reg, carry_next;

    logic              sel;
    logic [TICK_W-1:0] ticks_inc;
    logic              expire;
    logic              demote;

    assign sel       = (cmd.slot == SLOT_W'(IDX));
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : TICK_W'(ticks_reg + 8'd1);
    assign expire    = !cmd.boost && (ticks_inc >= cmd.slices[level_reg]);
    assign demote    = sel && cmd.exec && (cmd.op == OP_TICK) && cmd.running && expire
                       && !yield_reg && (level_reg != LVL_LAST);

    assign resp.level  = sel ? level_reg : '0;
    assign resp.demote = demote;
    assign carry_out   = carry_reg;

    always_comb
    begin
        level_next = level_reg;
        ticks_next = ticks_reg;
        yield_next = yield_reg;
        carry_next = carry_in;
        if (cmd.exec && sel)
        begin
            case (cmd.op)
                OP_ADD:
                begin
                    level_next = '0;
                    ticks_next = '0;
                    yield_next = 1'b0;
                end
                OP_TICK:
                begin
                    if (cmd.running)
                    begin
                        ticks_next = ticks_inc;
                        if (expire)
                        begin
                            if (yield_reg)
                                yield_next = 1'b0;
                            else if (level_reg != LVL_LAST)
                                level_next = LVL_W'(level_reg + 2'd1);
                            ticks_next = '0;
                        end
                    end
                end
                OP_YIELD:
                begin
                    yield_next = 1'b1;
                    ticks_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        // token pass: boost overrides whatever the tick did to this slot
        if (carry_in.active)
        begin
            if (carry_in.boost && live_bit)
            begin
                if (level_reg != '0)
                begin
                    carry_next.counts[level_reg] = cnt_dec(carry_in.counts[level_reg]);
                    carry_next.counts[0]         = cnt_inc(carry_in.counts[0]);
                end
                level_next = '0;
                ticks_next = '0;
            end
            if (carry_in.pick && run_bit && !carry_in.hit[level_reg])
            begin
                carry_next.hit[level_reg] = 1'b1;
                carry_next.idx[level_reg] = SLOT_W'(IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            ticks_reg <= '0;
            yield_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            ticks_reg <= ticks_next;
            yield_reg <= yield_next;
            carry_reg <= carry_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mlfqs_ctrl.sv
// mlfqs_ctrl: sequencer, input and output words, config registers, boost timer, level counts
// depends on mlfqs_pkg
`default_nettype none

module mlfqs_ctrl #(
    parameter int SLOTS = 64
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [2:0]                          op,
    input  wire  [mlfqs_pkg::SLOT_W-1:0]        slot,
    input  wire                                 is_running,
    input  wire  [mlfqs_pkg::MASK_W-1:0]        runnable_mask,
    input  wire  [mlfqs_pkg::MASK_W-1:0]        live_mask,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                found,
    output logic [mlfqs_pkg::SLOT_W-1:0]        chosen_slot,
    output logic [mlfqs_pkg::LVL_W-1:0]         slot_level,
    output logic                                boosted,
    output logic                                demoted,
    output logic [mlfqs_pkg::CNT_W-1:0]         count_level0,
    output logic [mlfqs_pkg::CNT_W-1:0]         count_level1,
    output logic [mlfqs_pkg::CNT_W-1:0]         count_level2,
    output logic [mlfqs_pkg::CNT_W-1:0]         count_level3,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [mlfqs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [mlfqs_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mlfqs_pkg::cmd_t                     cmd,
    output logic [mlfqs_pkg::MASK_W-1:0]        runnable_reg,
    output logic [mlfqs_pkg::MASK_W-1:0]        live_reg,
    output mlfqs_pkg::carry_t                   head,
    input  mlfqs_pkg::carry_t                   tail,
    input  mlfqs_pkg::resp_t                    bus
);
    import mlfqs_pkg::*;

    state_t             state_reg, state_next;
    op_t                op_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               running_reg;
    slices_t            slices_reg;
    logic [TIMER_W-1:0] interval_reg;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    counts_t            counts_reg, counts_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  chosen_reg, chosen_next;
    logic               boost_reg;
    logic               demote_reg;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [SLOT_W-1:0]  out_chosen_reg;
    logic [LVL_W-1:0]   out_level_reg;
    logic               out_boosted_reg;
    logic               out_demoted_reg;
    counts_t            out_counts_reg;

    logic               exec;
    logic               slot_ok;
    logic               tick_do;
    logic [TIMER_W-1:0] timer_inc;
    logic               boost_now;
    logic               scan_need;
    logic               out_free;
    logic               load_out;
    logic               accept;
    logic [LVL_W-1:0]   lv_up;
    logic               pick_found;
    logic [SLOT_W-1:0]  pick_slot;

    assign exec      = (state_reg == ST_EXEC);
    assign slot_ok   = ({1'b0, slot_reg} < (SLOT_W + 1)'(SLOTS));
    assign tick_do   = (op_reg == OP_TICK) && slot_ok && running_reg;
    assign timer_inc = (timer_reg == TIMER_MAX) ? timer_reg : TIMER_W'(timer_reg + 16'd1);
    assign boost_now = tick_do && (timer_inc >= interval_reg);
    assign scan_need = (op_reg == OP_PICK) || boost_now;
    assign lv_up     = bus.level + 2'd1;
    assign out_free  = !out_valid_reg || out_ready;

    assign cmd.exec    = exec;
    assign cmd.op      = op_reg;
    assign cmd.slot    = slot_reg;
    assign cmd.running = running_reg;
    assign cmd.boost   = boost_now;
    assign cmd.slices  = slices_reg;

    assign head.active = exec && scan_need;
    assign head.boost  = boost_now;
    assign head.pick   = (op_reg == OP_PICK);
    assign head.hit    = '0;
    assign head.idx    = '0;
    assign head.counts = counts_reg;

    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign chosen_slot  = out_chosen_reg;
    assign slot_level   = out_level_reg;
    assign boosted      = out_boosted_reg;
    assign demoted      = out_demoted_reg;
    assign count_level0 = out_counts_reg[0];
    assign count_level1 = out_counts_reg[1];
    assign count_level2 = out_counts_reg[2];
    assign count_level3 = out_counts_reg[3];

    // lowest level that saw a runnable slot wins
    always_comb
    begin
        pick_found = 1'b0;
        pick_slot  = '0;
        for (int lv = LEVELS - 1; lv >= 0; lv--)
        begin
            if (tail.hit[lv])
            begin
                pick_found = 1'b1;
                pick_slot  = tail.idx[lv];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = scan_need ? ST_SCAN : ST_FIN;
            end
            ST_SCAN:
            begin
                if (tail.active)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    in_ready   = 1'b1;
                    state_next = in_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        counts_next = counts_reg;
        timer_next  = timer_reg;
        found_next  = found_reg;
        chosen_next = chosen_reg;
        if (exec)
        begin
            found_next  = 1'b0;
            chosen_next = '0;
            case (op_reg)
                OP_ADD:
                begin
                    if (slot_ok)
                        counts_next[0] = cnt_inc(counts_reg[0]);
                end
                OP_REMOVE:
                begin
                    if (slot_ok)
                        counts_next[bus.level] = cnt_dec(counts_reg[bus.level]);
                end
                OP_TICK:
                begin
                    if (tick_do)
                    begin
                        timer_next = boost_now ? '0 : timer_inc;
                        if (bus.demote)
                        begin
                            counts_next[bus.level] = cnt_dec(counts_reg[bus.level]);
                            counts_next[lv_up]     = cnt_inc(counts_reg[lv_up]);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if ((state_reg == ST_SCAN) && tail.active)
        begin
            counts_next = tail.counts;
            if (tail.pick)
            begin
                found_next  = pick_found;
                chosen_next = pick_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timer_reg     <= '0;
            counts_reg    <= '0;
            out_valid_reg <= 1'b0;
            slices_reg[0] <= 8'd1;
            slices_reg[1] <= 8'd2;
            slices_reg[2] <= 8'd4;
            slices_reg[3] <= 8'd8;
            interval_reg  <= 16'd100;
        end
        else
        begin
            state_reg  <= state_next;
            timer_reg  <= timer_next;
            counts_reg <= counts_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SLICE0:   slices_reg[0] <= cfg_data[TICK_W-1:0];
                    REG_SLICE1:   slices_reg[1] <= cfg_data[TICK_W-1:0];
                    REG_SLICE2:   slices_reg[2] <= cfg_data[TICK_W-1:0];
                    REG_SLICE3:   slices_reg[3] <= cfg_data[TICK_W-1:0];
                    REG_INTERVAL: interval_reg  <= cfg_data[TIMER_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        chosen_reg <= chosen_next;
        if (exec)
        begin
            boost_reg  <= boost_now;
            demote_reg <= bus.demote;
        end
        if (accept)
        begin
            op_reg       <= op_t'(op);
            slot_reg     <= slot;
            running_reg  <= is_running;
            runnable_reg <= runnable_mask;
            live_reg     <= live_mask;
        end
        if (load_out)
        begin
            out_found_reg   <= found_reg;
            out_chosen_reg  <= chosen_reg;
            out_level_reg   <= bus.level;
            out_boosted_reg <= boost_reg;
            out_demoted_reg <= demote_reg;
            out_counts_reg  <= counts_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mlfq_process_scheduler_top.sv
// four-level feedback-queue scheduler over SLOTS process slots.
// channels: input word (op, slot, is_running, runnable_mask, live_mask) on in_valid/in_ready,
// one result word per input word on out_valid/out_ready, register writes on cfg_valid/cfg_ready
// with cfg_index 0..3 slice_level0..3 and 4 boost_interval; cfg_ready is always high and
// writes belong only to quiet periods.
// each slot lives in its own cell; add, remove, tick and yield go to the addressed cell
// in the EXEC state and then finish in FIN, where the next word can be accepted.
// pick and a tick that fires a boost send a token down the row of cells, one cell per
// cycle, collecting the pick per level and the level counts before the word reaches FIN.
// the result sits in an output register: the next word is accepted while it waits.
// when the receiver stalls, a finished word holds the sequencer until the output frees.
// reset: all slots at level 0 with no ticks or yield, counts and boost timer zero,
// slices 1, 2, 4, 8 and boost interval 100; the block is ready right after reset.
// depends on mlfqs_pkg, mlfqs_cell, mlfqs_ctrl
`default_nettype none

module mlfq_process_scheduler_top #(
    parameter int SLOTS = 64
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [2:0]                          op,
    input  wire  [mlfqs_pkg::SLOT_W-1:0]        slot,
    input  wire                                 is_running,
    input  wire  [mlfqs_pkg::MASK_W-1:0]        runnable_mask,
    input  wire  [mlfqs_pkg::MASK_W-1:0]        live_mask,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                found,
    output logic [mlfqs_pkg::SLOT_W-1:0]        chosen_slot,
    output logic [mlfqs_pkg::LVL_W-1:0]         slot_level,
    output logic                                boosted,
    output logic                                demoted,
    output logic [mlfqs_pkg::CNT_W-1:0]         count_level0,
    output logic [mlfqs_pkg::CNT_W-1:0]         count_level1,
    output logic [mlfqs_pkg::CNT_W-1:0]         count_level2,
    output logic [mlfqs_pkg::CNT_W-1:0]         count_level3,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [mlfqs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [mlfqs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mlfqs_pkg::*;

    cmd_t               cmd;
    logic [MASK_W-1:0]  runnable_reg;
    logic [MASK_W-1:0]  live_reg;
    carry_t             chain [SLOTS+1];
    resp_t              resp  [SLOTS];
    resp_t              bus;

    mlfqs_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .slot          (slot),
        .is_running    (is_running),
        .runnable_mask (runnable_mask),
        .live_mask     (live_mask),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .chosen_slot   (chosen_slot),
        .slot_level    (slot_level),
        .boosted       (boosted),
        .demoted       (demoted),
        .count_level0  (count_level0),
        .count_level1  (count_level1),
        .count_level2  (count_level2),
        .count_level3  (count_level3),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .runnable_reg  (runnable_reg),
        .live_reg      (live_reg),
        .head          (chain[0]),
        .tail          (chain[SLOTS]),
        .bus           (bus)
    );

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        mlfqs_cell #(
            .IDX(i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .live_bit  (live_reg[i]),
            .run_bit   (runnable_reg[i]),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1]),
            .resp      (resp[i])
        );
    end

    // only the addressed cell drives a nonzero answer
    always_comb
    begin
        bus = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            bus.level  = bus.level | resp[i].level;
            bus.demote = bus.demote | resp[i].demote;
        end
    end

endmodule

`default_nettype wire
